FILE: hdl/bht_pkg.sv
// Shared constants, types and codes for the 2x2 block halftone.
`default_nettype none
package bht_pkg;

    localparam int MaxWidth  = 1024;
    localparam int MaxHeight = 1024;

    localparam int ColW    = $clog2(MaxWidth);
    localparam int RowW    = $clog2(MaxHeight);
    localparam int HalfDep = MaxWidth / 2;
    localparam int HalfAw  = $clog2(HalfDep);

    localparam int SizeW  = 11;
    localparam int CoordW = 10;
    localparam int PixW   = 8;
    localparam int SumW   = PixW + 2;

    localparam logic [SumW-1:0] ThrTl = SumW'((1 * 1024) / 8);
    localparam logic [SumW-1:0] ThrBr = SumW'((3 * 1024) / 8);
    localparam logic [SumW-1:0] ThrBl = SumW'((5 * 1024) / 8);
    localparam logic [SumW-1:0] ThrTr = SumW'((7 * 1024) / 8);
    localparam logic [PixW-1:0] FullOn = 8'd255;

    localparam logic [2:0] BlockBeats = 3'd4;
    localparam logic [2:0] PassBeats  = 3'd1;

    localparam logic CfgWidth  = 1'b0;
    localparam logic CfgHeight = 1'b1;

    typedef enum logic {
        KIND_PASS,
        KIND_BLOCK
    } t_kind;

    typedef struct packed {
        t_kind            kind;
        logic [RowW-1:0]  row;
        logic [ColW-1:0]  col;
        logic [PixW-1:0]  pix;
        logic [SumW-1:0]  sum;
    } t_item;

endpackage
`default_nettype wire

FILE: hdl/bht_emit.sv
// Result buffer that expands one finished item into its output beats.
`default_nettype none
module bht_emit (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_load,
    input  wire bht_pkg::t_item            i_item,
    output logic                           o_free,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic [bht_pkg::CoordW-1:0]     o_out_row,
    output logic [bht_pkg::CoordW-1:0]     o_out_column,
    output logic [bht_pkg::PixW-1:0]       o_out_value,
    output logic                           o_last_of_run
);

    logic [2:0]     r_left;
    bht_pkg::t_item r_item;
    logic [bht_pkg::RowW-1:0] row_up;
    logic [bht_pkg::ColW-1:0] col_left;

    assign o_valid = (r_left != 3'd0);
    assign o_free  = (r_left == 3'd0) || (r_left == 3'd1 && i_ready);
    assign row_up   = r_item.row - bht_pkg::RowW'(1);
    assign col_left = r_item.col - bht_pkg::ColW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 3'd0;
        end else if (i_load && o_free) begin
            r_left <= (i_item.kind == bht_pkg::KIND_BLOCK) ? bht_pkg::BlockBeats
                                                            : bht_pkg::PassBeats;
        end else if (o_valid && i_ready) begin
            r_left <= r_left - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            r_item <= i_item;
        end
    end

    always_comb begin
        o_out_row     = bht_pkg::CoordW'(r_item.row);
        o_out_column  = bht_pkg::CoordW'(r_item.col);
        o_out_value   = r_item.pix;
        o_last_of_run = 1'b1;
        if (r_item.kind == bht_pkg::KIND_BLOCK) begin
            unique case (r_left)
                3'd4: begin
                    o_out_row     = bht_pkg::CoordW'(row_up);
                    o_out_column  = bht_pkg::CoordW'(col_left);
                    o_out_value   = (r_item.sum > bht_pkg::ThrTl) ? bht_pkg::FullOn : '0;
                    o_last_of_run = 1'b0;
                end
                3'd3: begin
                    o_out_value   = (r_item.sum > bht_pkg::ThrBr) ? bht_pkg::FullOn : '0;
                    o_last_of_run = 1'b0;
                end
                3'd2: begin
                    o_out_column  = bht_pkg::CoordW'(col_left);
                    o_out_value   = (r_item.sum > bht_pkg::ThrBl) ? bht_pkg::FullOn : '0;
                    o_last_of_run = 1'b0;
                end
                default: begin
                    o_out_row     = bht_pkg::CoordW'(row_up);
                    o_out_value   = (r_item.sum > bht_pkg::ThrTr) ? bht_pkg::FullOn : '0;
                end
            endcase
        end
    end

    a_left_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= bht_pkg::BlockBeats)
        else $error("beat count out of range");

    a_pass_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_load && o_free && i_item.kind == bht_pkg::KIND_PASS) |=> (r_left == 3'd1))
        else $error("pass-through item must give one beat");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && r_left == 3'd1 && !i_load) |=> !o_valid)
        else $error("buffer did not empty after final beat");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_left > 3'd1) |-> !o_free)
        else $error("buffer offered for load while beats remain");

endmodule
`default_nettype wire

FILE: hdl/block_halftone_2x2.sv
// Top level of the 2x2 block ordered-dither halftone.
// Pixels enter in raster order on the i_valid/o_ready channel, one 8-bit grey
// level per beat. Results leave on the o_valid/i_ready channel with their row,
// column, value and a flag on the final beat caused by each input pixel.
// Pixels of even block rows go to a line store made of two synchronous
// memories, one per column parity. The bottom-right pixel of a block reads both
// halves at once; its four results follow one per cycle while i_ready is high.
// Pixels outside a block give one pass-through beat; other block pixels give
// none. The first result beat passes through the item register and then the
// result buffer, and waits in the item register while the buffer is busy.
// A pixel is taken every cycle while the result buffer keeps up; a
// bottom-right pixel holds the buffer for its four result beats, so odd block
// rows run slower than even rows, a limit set by the single result channel.
// Write the image size registers via i_cfg_we, i_cfg_index and i_cfg_data only
// while the block is idle; the block itself does not enforce this. Reset clears
// the counters and sets both sizes to 1024; the line store is not cleared and
// needs no sweep. When the receiver stalls, the one-stage item register and
// the result buffer fill and o_ready drops until beats are taken again.
`default_nettype none
module block_halftone_2x2 (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic                      i_cfg_index,
    input  wire logic [bht_pkg::SizeW-1:0] i_cfg_data,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic [bht_pkg::PixW-1:0]  i_pixel,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic [bht_pkg::CoordW-1:0]     o_out_row,
    output logic [bht_pkg::CoordW-1:0]     o_out_column,
    output logic [bht_pkg::PixW-1:0]       o_out_value,
    output logic                           o_last_of_run
);

    localparam int ColW = bht_pkg::ColW;
    localparam int RowW = bht_pkg::RowW;
    localparam int PixW = bht_pkg::PixW;
    localparam int SumW = bht_pkg::SumW;

    logic [bht_pkg::SizeW-1:0] r_width, r_height;
    logic [ColW:0]   w_eff, w_blk, col_inc;
    logic [RowW:0]   h_eff, h_blk, row_a1, row_b;
    logic [ColW-1:0] r_col, n_col, col_a;
    logic [RowW-1:0] r_row, n_row, row_a;
    logic            wrap_a, in_block, gives_result, accept, is_sum;

    logic [PixW-1:0] r_mem_even [bht_pkg::HalfDep];
    logic [PixW-1:0] r_mem_odd  [bht_pkg::HalfDep];
    logic [PixW-1:0] r_rd_even, r_rd_odd, r_held;
    logic [bht_pkg::HalfAw-1:0] mem_addr;

    logic            r_s1_valid;
    bht_pkg::t_kind  r_s1_kind;
    logic [RowW-1:0] r_s1_row;
    logic [ColW-1:0] r_s1_col;
    logic [PixW-1:0] r_s1_pix;
    bht_pkg::t_item  s1_item;
    logic            emit_free, s1_move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= bht_pkg::SizeW'(1024);
            r_height <= bht_pkg::SizeW'(1024);
        end else if (i_cfg_we) begin
            if (i_cfg_index == bht_pkg::CfgWidth) begin
                r_width <= i_cfg_data;
            end else begin
                r_height <= i_cfg_data;
            end
        end
    end

    always_comb begin
        if (r_width == '0) begin
            w_eff = (ColW+1)'(1);
        end else if (32'(r_width) > bht_pkg::MaxWidth) begin
            w_eff = (ColW+1)'(bht_pkg::MaxWidth);
        end else begin
            w_eff = (ColW+1)'(r_width);
        end
        if (r_height == '0) begin
            h_eff = (RowW+1)'(1);
        end else if (32'(r_height) > bht_pkg::MaxHeight) begin
            h_eff = (RowW+1)'(bht_pkg::MaxHeight);
        end else begin
            h_eff = (RowW+1)'(r_height);
        end
        w_blk = w_eff & ~(ColW+1)'(1);
        h_blk = h_eff & ~(RowW+1)'(1);
    end

    always_comb begin
        wrap_a   = ({1'b0, r_col} >= w_eff);
        col_a    = wrap_a ? '0 : r_col;
        row_a1   = {1'b0, r_row} + (RowW+1)'(wrap_a);
        row_a    = (row_a1 >= h_eff) ? '0 : row_a1[RowW-1:0];
        in_block = ({1'b0, col_a} < w_blk) && ({1'b0, row_a} < h_blk);
        is_sum   = in_block && row_a[0] && col_a[0];
        gives_result = !in_block || is_sum;
        col_inc  = {1'b0, col_a} + (ColW+1)'(1);
        row_b    = {1'b0, row_a} + (RowW+1)'(1);
        if (col_inc >= w_eff) begin
            n_col = '0;
            n_row = (row_b >= h_eff) ? '0 : row_b[RowW-1:0];
        end else begin
            n_col = col_inc[ColW-1:0];
            n_row = row_a;
        end
        mem_addr = col_a[ColW-1:1];
    end

    assign s1_move = r_s1_valid && emit_free;
    assign o_ready = !r_s1_valid || emit_free;
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_held     <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
                if (in_block && row_a[0] && !col_a[0]) begin
                    r_held <= i_pixel;
                end
            end
            if (accept && gives_result) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && in_block && !row_a[0]) begin
            if (col_a[0]) begin
                r_mem_odd[mem_addr] <= i_pixel;
            end else begin
                r_mem_even[mem_addr] <= i_pixel;
            end
        end
        if (accept && is_sum) begin
            r_rd_even <= r_mem_even[mem_addr];
            r_rd_odd  <= r_mem_odd[mem_addr];
        end
        if (accept && gives_result) begin
            r_s1_kind <= in_block ? bht_pkg::KIND_BLOCK : bht_pkg::KIND_PASS;
            r_s1_row  <= row_a;
            r_s1_col  <= col_a;
            r_s1_pix  <= i_pixel;
        end
    end

    always_comb begin
        s1_item.kind = r_s1_kind;
        s1_item.row  = r_s1_row;
        s1_item.col  = r_s1_col;
        s1_item.pix  = r_s1_pix;
        s1_item.sum  = SumW'(r_rd_even) + SumW'(r_rd_odd) + SumW'(r_held) + SumW'(r_s1_pix);
    end

    bht_emit u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (r_s1_valid),
        .i_item        (s1_item),
        .o_free        (emit_free),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_row     (o_out_row),
        .o_out_column  (o_out_column),
        .o_out_value   (o_out_value),
        .o_last_of_run (o_last_of_run)
    );

    a_stall_holds_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !emit_free) |=> (r_s1_valid && $stable(r_s1_col) && $stable(r_s1_row)))
        else $error("pending item lost while result buffer was busy");

    a_no_accept_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !emit_free) |-> !o_ready)
        else $error("pixel accepted while item register was occupied");

    a_counters_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> ({1'b0, r_col} < $past(w_eff)))
        else $error("column counter left the row");

endmodule
`default_nettype wire
